/* design/sparse_set_index_list_top_macros.svh */
// Assertion macros used by the checker file of the sparse set index list.
`ifndef SPARSE_SET_INDEX_LIST_TOP_MACROS_SVH
`define SPARSE_SET_INDEX_LIST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSIL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold at the edge after each edge at which rst_n is low.
`define SSIL_ASSERT_IN_RESET(label, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* design/ssil_pkg.sv */
// Types and constants of the sparse set index list.
package ssil_pkg;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int CMP_W    = FIELD_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_ID_AT  = 2'd1,
        OP_POS_OF = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 3'd0,
        STATUS_RANGE  = 3'd1,
        STATUS_FULL   = 3'd2,
        STATUS_EMPTY  = 3'd3,
        STATUS_ABSENT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_LOOKUP,
        S_VERIFY,
        S_MOVE
    } state_t;

endpackage

/* design/sparse_set_index_list_top.sv */
// Sparse set of object ids kept as a dense list and a reverse map, one operation per item.
//
//  channel  handshake            payload
//  req      req_valid/req_stall  op, object_id, position
//  rsp      rsp_valid/rsp_stall  status, value, entry_count
//
// An append, and any item rejected at its first check, ends in S_CHECK; id at position
// and removal read the dense list and end in S_FETCH and S_MOVE; position of id reads the
// reverse map and ends in S_LOOKUP if that entry is not below the count, else in S_VERIFY.
// Registered read ports of both memories set these steps; one count comparator is shared.
// After reset a clearing pass zeroes the reverse map with req_stall high.
// A result waits in the output register; the block holds its last step while it is stalled.
module sparse_set_index_list_top
    import ssil_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [FIELD_W-1:0]  object_id,
    input  logic [FIELD_W-1:0]  position,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  value,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;
    logic [CW-1:0]       count_reg, count_next;
    op_t                 op_reg, op_next;
    logic [FIELD_W-1:0]  id_reg, id_next;
    logic [FIELD_W-1:0]  pos_reg, pos_next;
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             status_reg, status_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0]  entry_count_reg, entry_count_next;

    logic [AW-1:0]       dense_mem [CAPACITY];
    logic [AW-1:0]       map_mem [CAPACITY];
    logic [AW-1:0]       dense_rdata_reg;
    logic [AW-1:0]       map_rdata_reg;

    logic                dense_we, dense_re, map_we, map_re;
    logic [AW-1:0]       dense_waddr, dense_wdata, dense_raddr;
    logic [AW-1:0]       map_waddr, map_wdata, map_raddr;

    logic [CMP_W-1:0]    cmp_a;
    logic                cmp_ge;
    logic                out_free;
    logic                id_oor;
    logic                is_full;
    logic                is_empty;
    logic [CW-1:0]       last;
    logic                finish;
    status_t             fin_status;
    logic [VALUE_W-1:0]  fin_value;

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign value       = value_reg;
    assign entry_count = entry_count_reg;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign cmp_ge   = (cmp_a >= CMP_W'(count_reg));
    assign id_oor   = (CMP_W'(id_reg) >= CMP_W'(CAPACITY));
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign last     = count_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
        if (dense_re)
        begin
            dense_rdata_reg <= dense_mem[dense_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        id_reg          <= id_next;
        pos_reg         <= pos_next;
        status_reg      <= status_next;
        value_reg       <= value_next;
        entry_count_reg <= entry_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        count_next       = count_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        pos_next         = pos_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        status_next      = status_reg;
        value_next       = value_reg;
        entry_count_next = entry_count_reg;

        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        dense_re    = 1'b0;
        dense_raddr = '0;
        map_we      = 1'b0;
        map_waddr   = '0;
        map_wdata   = '0;
        map_re      = 1'b0;
        map_raddr   = '0;

        cmp_a      = CMP_W'(pos_reg);
        finish     = 1'b0;
        fin_status = STATUS_OK;
        fin_value  = '0;

        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_idx_reg;
                map_wdata = '0;
                if (clr_idx_reg == AW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = op_t'(op);
                    id_next    = object_id;
                    pos_next   = position;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (out_free)
                        begin
                            finish     = 1'b1;
                            state_next = S_IDLE;
                            if (id_oor)
                            begin
                                fin_status = STATUS_RANGE;
                            end
                            else if (is_full)
                            begin
                                fin_status = STATUS_FULL;
                            end
                            else
                            begin
                                dense_we    = 1'b1;
                                dense_waddr = count_reg[AW-1:0];
                                dense_wdata = id_reg[AW-1:0];
                                map_we      = 1'b1;
                                map_waddr   = id_reg[AW-1:0];
                                map_wdata   = count_reg[AW-1:0];
                                fin_value   = VALUE_W'(32'(count_reg));
                                count_next  = count_reg + CW'(1);
                            end
                        end
                    end

                    OP_ID_AT:
                    begin
                        if (cmp_ge)
                        begin
                            if (out_free)
                            begin
                                finish     = 1'b1;
                                fin_status = STATUS_RANGE;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            dense_re    = 1'b1;
                            dense_raddr = pos_reg[AW-1:0];
                            state_next  = S_FETCH;
                        end
                    end

                    OP_POS_OF:
                    begin
                        if (id_oor)
                        begin
                            if (out_free)
                            begin
                                finish     = 1'b1;
                                fin_status = STATUS_RANGE;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            map_re     = 1'b1;
                            map_raddr  = id_reg[AW-1:0];
                            state_next = S_LOOKUP;
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (is_empty || cmp_ge)
                        begin
                            if (out_free)
                            begin
                                finish     = 1'b1;
                                fin_status = is_empty ? STATUS_EMPTY : STATUS_RANGE;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            dense_re    = 1'b1;
                            dense_raddr = last[AW-1:0];
                            state_next  = S_MOVE;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FETCH:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    fin_value  = VALUE_W'(32'(dense_rdata_reg));
                    state_next = S_IDLE;
                end
            end

            S_LOOKUP:
            begin
                cmp_a = CMP_W'(map_rdata_reg);
                if (cmp_ge)
                begin
                    if (out_free)
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_ABSENT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    dense_re    = 1'b1;
                    dense_raddr = map_rdata_reg;
                    state_next  = S_VERIFY;
                end
            end

            S_VERIFY:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                    if (dense_rdata_reg != id_reg[AW-1:0])
                    begin
                        fin_status = STATUS_ABSENT;
                    end
                    else
                    begin
                        fin_value = VALUE_W'(32'(map_rdata_reg));
                    end
                end
            end

            S_MOVE:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    fin_value  = VALUE_W'(32'(last));
                    count_next = last;
                    state_next = S_IDLE;
                    if (CMP_W'(pos_reg) != CMP_W'(last))
                    begin
                        dense_we    = 1'b1;
                        dense_waddr = pos_reg[AW-1:0];
                        dense_wdata = dense_rdata_reg;
                        map_we      = 1'b1;
                        map_waddr   = dense_rdata_reg;
                        map_wdata   = pos_reg[AW-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            rsp_valid_next   = 1'b1;
            status_next      = fin_status;
            value_next       = fin_value;
            entry_count_next = COUNT_W'(32'(count_next));
        end
    end

endmodule

/* design/ssil_chk.sv */
// Port-level checker for the sparse set index list and its bind to the top level.
`include "sparse_set_index_list_top_macros.svh"

module ssil_chk
    import ssil_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input logic [STATUS_W-1:0] status,
    input logic [VALUE_W-1:0]  value,
    input logic [COUNT_W-1:0]  entry_count
);

    `SSIL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(value) && $stable(entry_count), "stalled result changed")
    `SSIL_ASSERT_SAME(a_err_zero, rsp_valid && (status != STATUS_OK), value == '0, "error result with nonzero value")
    `SSIL_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "item accepted while another is in work")
    `SSIL_ASSERT_SAME(a_rsp_cause, $rose(rsp_valid), $past(req_stall), "result without an item in work")
    `SSIL_ASSERT_IN_RESET(a_rst_quiet, !rsp_valid, "result shown during reset")

endmodule

bind sparse_set_index_list_top ssil_chk u_ssil_chk (.*);

/* tb/tb_sparse_set_index_list_top.sv */
// Self-checking testbench of the sparse set index list: queued stimulus, prediction and checking.
module tb_sparse_set_index_list_top;
    import ssil_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_EPOCHS = 6;
    localparam int EPOCH_ITEMS = 85;

    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] object_id;
        logic [FIELD_W-1:0] position;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  entry_count;
    } reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [OP_W-1:0]     op = OP_APPEND;
    logic [FIELD_W-1:0]  object_id = '0;
    logic [FIELD_W-1:0]  position = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  entry_count;

    logic [VALUE_W-1:0] list_ids [CAPACITY];
    logic [VALUE_W-1:0] id_slot [CAPACITY];
    int                 list_count = 0;

    request_t    pending_requests [$];
    reply_t      expected_replies [$];
    request_t    current_request;
    reply_t      oldest_reply;
    int unsigned send_gap = 0;
    int unsigned receive_wait = 0;
    bit          send_calm = 1'b0;
    bit          receive_calm = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    sparse_set_index_list_top #(.CAPACITY(CAPACITY)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .object_id   (object_id),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .value       (value),
        .entry_count (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic reply_t predict_reply(request_t r);
        reply_t             e;
        logic [VALUE_W-1:0] moved;
        int                 slot;
        e.status = STATUS_OK;
        e.value = '0;
        case (r.op)
            OP_APPEND:
            begin
                if (r.object_id >= CAPACITY)
                    e.status = STATUS_RANGE;
                else if (list_count >= CAPACITY)
                    e.status = STATUS_FULL;
                else
                begin
                    list_ids[AW'(list_count)] = VALUE_W'(r.object_id);
                    id_slot[AW'(r.object_id)] = VALUE_W'(list_count);
                    e.value = VALUE_W'(list_count);
                    list_count++;
                end
            end
            OP_ID_AT:
            begin
                if (r.position >= list_count)
                    e.status = STATUS_RANGE;
                else
                    e.value = list_ids[AW'(r.position)];
            end
            OP_POS_OF:
            begin
                if (r.object_id >= CAPACITY)
                    e.status = STATUS_RANGE;
                else
                begin
                    slot = id_slot[AW'(r.object_id)];
                    if (slot >= list_count || list_ids[AW'(slot)] != VALUE_W'(r.object_id))
                        e.status = STATUS_ABSENT;
                    else
                        e.value = VALUE_W'(slot);
                end
            end
            default:
            begin
                if (list_count == 0)
                    e.status = STATUS_EMPTY;
                else if (r.position >= list_count)
                    e.status = STATUS_RANGE;
                else
                begin
                    list_count--;
                    if (r.position != list_count)
                    begin
                        moved = list_ids[AW'(list_count)];
                        list_ids[AW'(r.position)] = moved;
                        id_slot[AW'(moved)] = VALUE_W'(r.position);
                    end
                    e.value = VALUE_W'(list_count);
                end
            end
        endcase
        e.entry_count = COUNT_W'(list_count);
        return e;
    endfunction

    function automatic int unsigned draw_wait(ref bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic request_t make_request(op_t o, int id, int pos);
        request_t r;
        r.op = o;
        r.object_id = FIELD_W'(id);
        r.position = FIELD_W'(pos);
        return r;
    endfunction

    function automatic int random_id();
        case ($urandom_range(0, 9))
            0: return $urandom_range(CAPACITY, 16'hFFFF);
            1, 2, 3: return $urandom_range(0, 63);
            default: return $urandom_range(0, CAPACITY - 1);
        endcase
    endfunction

    function automatic int random_position();
        if (list_count > 0 && $urandom_range(0, 9) < 8)
        begin
            if ($urandom_range(0, 3) == 0)
                return list_count - 1;
            return $urandom_range(0, list_count - 1);
        end
        if ($urandom_range(0, 1) == 0)
            return list_count;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    function automatic request_t random_request(int unsigned append_pct, int unsigned remove_pct);
        request_t    r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        r.object_id = FIELD_W'($urandom_range(0, 16'hFFFF));
        r.position = FIELD_W'($urandom_range(0, 16'hFFFF));
        if (roll < append_pct)
        begin
            r.op = OP_APPEND;
            r.object_id = FIELD_W'(random_id());
        end
        else if (roll < append_pct + remove_pct)
        begin
            r.op = OP_REMOVE;
            r.position = FIELD_W'(random_position());
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            r.op = OP_ID_AT;
            r.position = FIELD_W'(random_position());
        end
        else
        begin
            r.op = OP_POS_OF;
            if (list_count > 0 && $urandom_range(0, 1) == 0)
                r.object_id = FIELD_W'(list_ids[AW'($urandom_range(0, list_count - 1))]);
            else
                r.object_id = FIELD_W'(random_id());
        end
        return r;
    endfunction

    task automatic queue_request(request_t r);
        while (pending_requests.size() >= 2)
            @(posedge clk);
        pending_requests.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_valid || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            op <= OP_APPEND;
            object_id <= '0;
            position <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_replies.push_back(predict_reply(current_request));
            if (req_valid && req_stall)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                current_request = pending_requests.pop_front();
                op <= current_request.op;
                object_id <= current_request.object_id;
                position <= current_request.position;
                req_valid <= 1'b1;
                send_gap = draw_wait(send_calm);
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("reply with none expected, status", status, 0);
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    if (status !== oldest_reply.status)
                        report_mismatch("status", status, oldest_reply.status);
                    if (value !== oldest_reply.value)
                        report_mismatch("value", value, oldest_reply.value);
                    if (entry_count !== oldest_reply.entry_count)
                        report_mismatch("entry_count", entry_count, oldest_reply.entry_count);
                end
                receive_wait = draw_wait(receive_calm);
            end
            else if (receive_wait > 0)
                receive_wait--;
            rsp_stall <= (receive_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned append_mix [RANDOM_EPOCHS] = '{60, 25, 10, 40, 20, 30};
        int unsigned remove_mix [RANDOM_EPOCHS] = '{10, 25, 60, 20, 40, 30};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_request(make_request(OP_ID_AT, 16'hFFFF, 0));
        queue_request(make_request(OP_ID_AT, 0, 16'hFFFF));
        queue_request(make_request(OP_REMOVE, 0, 0));
        queue_request(make_request(OP_POS_OF, 0, 0));
        queue_request(make_request(OP_POS_OF, CAPACITY, 0));
        queue_request(make_request(OP_POS_OF, 16'hFFFF, 0));
        queue_request(make_request(OP_APPEND, 16'hFFFF, 0));
        queue_request(make_request(OP_APPEND, CAPACITY, 0));
        queue_request(make_request(OP_APPEND, 0, 16'hFFFF));
        queue_request(make_request(OP_APPEND, CAPACITY - 1, 0));
        queue_request(make_request(OP_APPEND, 5, 0));
        queue_request(make_request(OP_APPEND, 5, 0));
        queue_request(make_request(OP_ID_AT, 0, 3));
        queue_request(make_request(OP_ID_AT, 0, 4));
        queue_request(make_request(OP_POS_OF, 5, 0));
        queue_request(make_request(OP_POS_OF, CAPACITY - 1, 0));
        queue_request(make_request(OP_REMOVE, 0, 0));
        queue_request(make_request(OP_REMOVE, 0, 2));
        queue_request(make_request(OP_REMOVE, 0, 16'hFFFF));
        queue_request(make_request(OP_POS_OF, 0, 0));
        queue_request(make_request(OP_POS_OF, 5, 0));
        queue_request(make_request(OP_ID_AT, 0, 1));

        for (int epoch = 0; epoch < RANDOM_EPOCHS; epoch++)
            for (int n = 0; n < EPOCH_ITEMS; n++)
                queue_request(random_request(append_mix[epoch], remove_mix[epoch]));

        wait_idle();
        queue_request(make_request(OP_APPEND, 7, 0));
        queue_request(make_request(OP_APPEND, 16'hFFFF, 0));
        queue_request(make_request(OP_ID_AT, 0, CAPACITY - 1));
        queue_request(make_request(OP_ID_AT, 0, CAPACITY));
        queue_request(make_request(OP_POS_OF, 7, 0));
        queue_request(make_request(OP_REMOVE, 0, CAPACITY - 1));
        queue_request(make_request(OP_REMOVE, 0, 0));
        queue_request(make_request(OP_APPEND, CAPACITY - 1, 0));
        queue_request(make_request(OP_APPEND, 3, 0));
        for (int n = 0; n < 60; n++)
            queue_request(random_request(5, 60));

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* sparse_set_index_list_top.f */
+incdir+design
design/ssil_pkg.sv
design/sparse_set_index_list_top.sv
design/ssil_chk.sv
tb/tb_sparse_set_index_list_top.sv
